// ===== rtl/mrlq_pkg.sv =====
// ----------------------------------------------------------------------------
// mrlq_pkg
// shared types and codes for the multi-resource lock queue
// ----------------------------------------------------------------------------
package mrlq_pkg;

	// fixed payload widths
	localparam int MASK_IN_W = 10;
	localparam int SLOT_W    = 4;
	localparam int HANDLE_W  = 4;
	localparam int KIND_W    = 2;

	// most results one input item may produce
	localparam int MAX_RESULTS = 16;

	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [1:0]        status_t;

	// command codes
	localparam logic CMD_ACQUIRE = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	// result kinds
	localparam kind_t KIND_ASSIGNED = 2'd0;
	localparam kind_t KIND_GRANTED  = 2'd1;
	localparam kind_t KIND_FULL     = 2'd2;
	localparam kind_t KIND_BADREL   = 2'd3;

	// ring entry status
	localparam status_t ST_FREE = 2'd0;
	localparam status_t ST_WAIT = 2'd1;
	localparam status_t ST_HELD = 2'd2;
	localparam status_t ST_DONE = 2'd3;

	// sequencer controls for the scan unit
	typedef struct packed {
		logic clr;
		logic eval;
		logic adv;
	} scan_ctl_t;

endpackage

// ===== rtl/mrlq_req_if.sv =====
// ----------------------------------------------------------------------------
// mrlq_req_if
// request channel: acquire or release commands
// ----------------------------------------------------------------------------
interface mrlq_req_if;
	import mrlq_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 cmd;
	logic [MASK_IN_W-1:0] resource_mask;
	logic [SLOT_W-1:0]    slot;

	modport source (output valid, output cmd, output resource_mask, output slot, input ready);
	modport sink   (input valid, input cmd, input resource_mask, input slot, output ready);

endinterface

// ===== rtl/mrlq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mrlq_rsp_if
// result channel: handles, grants and errors
// ----------------------------------------------------------------------------
interface mrlq_rsp_if;
	import mrlq_pkg::*;

	logic                valid;
	logic                ready;
	kind_t               kind;
	logic [HANDLE_W-1:0] handle;
	logic                last;

	modport source (output valid, output kind, output handle, output last, input ready);
	modport sink   (input valid, input kind, input handle, input last, output ready);

endinterface

// ===== rtl/multi_resource_lock_queue_top.sv =====
// ----------------------------------------------------------------------------
// multi_resource_lock_queue_top
// fifo ring of multi-resource lock requests, granted in ring order when no earlier live entry shares a resource
// ----------------------------------------------------------------------------
// flow: an acquire scans the live entries, a release first frees released
//   entries at the head and then scans; an error result skips the scan
// a new request is taken only once the final result of the previous one is in
//   the output register; the ring scan and result stalls set the pace
// reset: status all free, head and tail at zero; the mask ram is not cleared
// ----------------------------------------------------------------------------
module multi_resource_lock_queue_top #(
	parameter int RING_DEPTH     = 16,
	parameter int RESOURCE_COUNT = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	mrlq_req_if.sink  req,
	mrlq_rsp_if.source rsp
);
	import mrlq_pkg::*;

	localparam int SW = $clog2(RING_DEPTH);
	localparam int PW = SW + 1;
	localparam int MW = (RESOURCE_COUNT < MASK_IN_W) ? RESOURCE_COUNT : MASK_IN_W;
	localparam int NW = $clog2(MAX_RESULTS + 1);

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_HEAD  = 3'd1;
	localparam logic [2:0] S_PRIME = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_FLUSH = 3'd4;

	logic [2:0]    state_q;
	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [PW-1:0] p_q;
	status_t       status_q [RING_DEPTH];

	// one result held back until we know whether it is the last one
	logic                pend_v_q;
	kind_t               pend_kind_q;
	logic [HANDLE_W-1:0] pend_handle_q;
	logic [NW-1:0]       n_q;

	// output register
	logic                out_valid_q;
	kind_t               out_kind_q;
	logic [HANDLE_W-1:0] out_handle_q;
	logic                out_last_q;

	logic          acc;
	logic [PW-1:0] used;
	logic          full;
	logic [SW-1:0] rel_idx;
	logic          rel_oob;
	logic          rel_bad;
	logic          out_free;
	logic [SW-1:0] cur;
	logic [PW-1:0] p_nxt;
	logic [SW-1:0] hd;
	logic          hd_done;
	logic          cap_ok;
	logic          grant;
	logic          stall;
	logic          push;
	logic          push_last;
	logic          ram_we;
	logic [SW-1:0] ram_raddr;
	logic [MW-1:0] ram_rdata;
	scan_ctl_t     ctl;

	// input side
	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && (state_q == S_IDLE);

	// ring occupancy; positions run modulo twice the depth
	assign used = tail_q - head_q;
	assign full = used[PW-1];

	// release check: slot in range and currently held
	assign rel_idx = SW'(req.slot);
	assign rel_oob = 32'(req.slot) >= 32'(RING_DEPTH);
	assign rel_bad = rel_oob || (status_q[rel_idx] != ST_HELD);

	assign out_free = !out_valid_q || rsp.ready;

	// scan pointer and head walk
	assign cur     = p_q[SW-1:0];
	assign p_nxt   = p_q + PW'(1);
	assign hd      = head_q[SW-1:0];
	assign hd_done = (head_q != tail_q) && (status_q[hd] == ST_DONE);
	assign cap_ok  = n_q < NW'(MAX_RESULTS);

	// with a result pending the scan waits for room in the output register
	assign ctl.clr  = (state_q == S_PRIME);
	assign ctl.eval = (state_q == S_SCAN) && (p_q != tail_q);
	assign stall    = pend_v_q && !out_free;
	assign ctl.adv  = (state_q == S_SCAN) && (p_q != tail_q) && !stall;

	// read address runs one entry ahead so the ram keeps pace with the scan
	always_comb begin
		if (state_q == S_SCAN) begin
			ram_raddr = ctl.adv ? p_nxt[SW-1:0] : cur;
		end else begin
			ram_raddr = hd;
		end
	end

	assign ram_we = acc && (req.cmd == CMD_ACQUIRE) && !full;

	mrlq_ram #(
		.WIDTH (MW),
		.DEPTH (RING_DEPTH)
	) u_mask_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q[SW-1:0]),
		.wdata (req.resource_mask[MW-1:0]),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mrlq_scan_unit #(
		.MASK_W (MW)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.status (status_q[cur]),
		.mask   (ram_rdata),
		.cap_ok (cap_ok),
		.grant  (grant)
	);

	// a new grant pushes the previous result out; flush marks the final one
	assign push      = (ctl.adv && grant && pend_v_q) ||
	                   ((state_q == S_FLUSH) && pend_v_q && out_free);
	assign push_last = (state_q == S_FLUSH);

	// sequencer and ring status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			p_q      <= '0;
			pend_v_q <= 1'b0;
			n_q      <= '0;
			for (int i = 0; i < RING_DEPTH; i++) begin
				status_q[i] <= ST_FREE;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (req.cmd == CMD_ACQUIRE) begin
							pend_v_q <= 1'b1;
							n_q      <= NW'(1);
							if (full) begin
								state_q <= S_FLUSH;
							end else begin
								status_q[tail_q[SW-1:0]] <= ST_WAIT;
								tail_q  <= tail_q + PW'(1);
								state_q <= S_PRIME;
							end
						end else if (rel_bad) begin
							pend_v_q <= 1'b1;
							n_q      <= NW'(1);
							state_q  <= S_FLUSH;
						end else begin
							status_q[rel_idx] <= ST_DONE;
							pend_v_q <= 1'b0;
							n_q      <= '0;
							state_q  <= S_HEAD;
						end
					end
				end
				S_HEAD: begin
					// free released entries at the head, one per cycle
					if (hd_done) begin
						status_q[hd] <= ST_FREE;
						head_q       <= head_q + PW'(1);
					end else begin
						state_q <= S_PRIME;
					end
				end
				S_PRIME: begin
					p_q     <= head_q;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (!ctl.eval) begin
						state_q <= S_FLUSH;
					end else if (ctl.adv) begin
						p_q <= p_nxt;
						if (grant) begin
							status_q[cur] <= ST_HELD;
							pend_v_q      <= 1'b1;
							n_q           <= n_q + NW'(1);
						end
					end
				end
				S_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// pending result payload
	always_ff @(posedge clk) begin
		if (acc) begin
			if (req.cmd == CMD_ACQUIRE) begin
				pend_kind_q   <= full ? KIND_FULL : KIND_ASSIGNED;
				pend_handle_q <= full ? '0 : HANDLE_W'(tail_q[SW-1:0]);
			end else begin
				pend_kind_q   <= KIND_BADREL;
				pend_handle_q <= req.slot;
			end
		end else if (ctl.adv && grant) begin
			pend_kind_q   <= KIND_GRANTED;
			pend_handle_q <= HANDLE_W'(cur);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_kind_q   <= pend_kind_q;
			out_handle_q <= pend_handle_q;
			out_last_q   <= push_last;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.kind   = out_kind_q;
	assign rsp.handle = out_handle_q;
	assign rsp.last   = out_last_q;

endmodule

// ===== rtl/mrlq_ram.sv =====
// ----------------------------------------------------------------------------
// mrlq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module mrlq_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/mrlq_scan_unit.sv =====
// ----------------------------------------------------------------------------
// mrlq_scan_unit
// conflict check for one ring entry per step, accumulating the busy set
// ----------------------------------------------------------------------------
module mrlq_scan_unit #(
	parameter int MASK_W = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mrlq_pkg::scan_ctl_t ctl,
	input  mrlq_pkg::status_t   status,
	input  logic [MASK_W-1:0]   mask,
	input  logic                cap_ok,
	output logic                grant
);
	import mrlq_pkg::*;

	logic [MASK_W-1:0] busy_q;
	logic              live;

	// waiting entry with no overlap against earlier live entries, while result room is left
	assign grant = ctl.eval && (status == ST_WAIT) && ((mask & busy_q) == '0) && cap_ok;
	assign live  = (status == ST_WAIT) || (status == ST_HELD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else if (ctl.clr) begin
			busy_q <= '0;
		end else if (ctl.adv && live) begin
			busy_q <= busy_q | mask;
		end
	end

endmodule

// ===== rtl/mrlq_checker.sv =====
// ----------------------------------------------------------------------------
// mrlq_checker
// port-level checks on the lock queue, bound to the top level
// ----------------------------------------------------------------------------
module mrlq_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            req_valid,
	input logic                            req_ready,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input mrlq_pkg::kind_t                 rsp_kind,
	input logic [mrlq_pkg::HANDLE_W-1:0]   rsp_handle,
	input logic                            rsp_last
);
	import mrlq_pkg::*;

	// a pending result is not withdrawn
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// the block does not take a request in the cycle after accepting one
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken back to back");

	// rejects and bad releases are the only result of their command
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_kind == KIND_FULL || rsp_kind == KIND_BADREL) |-> rsp_last)
		else $error("error result not marked last");

	// a ring full reject carries handle zero
	a_full_handle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_kind == KIND_FULL) |-> (rsp_handle == '0))
		else $error("ring full reject with nonzero handle");

endmodule

bind multi_resource_lock_queue_top mrlq_checker u_mrlq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_kind   (rsp.kind),
	.rsp_handle (rsp.handle),
	.rsp_last   (rsp.last)
);

// ===== tb/sv/mrlq_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// mrlq_tb_pkg
// grant-order tracker for the lock queue: predicts the results of each
// accepted request and checks the block's results against them in order
// ----------------------------------------------------------------------------
package mrlq_tb_pkg;
	import mrlq_pkg::*;

	localparam int LOCK_RING_DEPTH = 16;
	localparam int LOCK_RESOURCES  = 10;

	typedef struct {
		kind_t               kind;
		logic [HANDLE_W-1:0] handle;
		logic                last;
	} lock_result_t;

	class lock_grant_tracker;
		logic [MASK_IN_W-1:0] slot_mask [LOCK_RING_DEPTH];
		status_t              slot_state [LOCK_RING_DEPTH];
		logic [SLOT_W:0]      head_ptr;
		logic [SLOT_W:0]      tail_ptr;
		lock_result_t         step_results [$];
		lock_result_t         owed_results [$];
		int                   mismatches;

		function new();
			foreach (slot_state[i]) begin
				slot_state[i] = ST_FREE;
				slot_mask[i]  = '0;
			end
			head_ptr   = '0;
			tail_ptr   = '0;
			mismatches = 0;
		endfunction

		function int live_count();
			logic [SLOT_W:0] used;
			used = tail_ptr - head_ptr;
			return int'(used);
		endfunction

		function int owed_count();
			return owed_results.size();
		endfunction

		function bit clean();
			return (mismatches == 0) && (owed_results.size() == 0);
		endfunction

		// random currently granted slot, or -1 when none is held
		function int pick_held_slot();
			int held [$];
			foreach (slot_state[i])
				if (slot_state[i] == ST_HELD)
					held.push_back(i);
			if (held.size() == 0)
				return -1;
			return held[$urandom_range(0, held.size() - 1)];
		endfunction

		function void add_result(kind_t kind, logic [HANDLE_W-1:0] handle);
			lock_result_t r;
			if (step_results.size() >= MAX_RESULTS)
				return;
			r.kind   = kind;
			r.handle = handle;
			r.last   = 1'b0;
			step_results.push_back(r);
		endfunction

		// grant waiters in ring order whose earlier live entries share no resource
		function void scan_grants();
			logic [MASK_IN_W-1:0] busy;
			logic [SLOT_W:0]      p;
			logic [SLOT_W-1:0]    s;
			busy = '0;
			p    = head_ptr;
			for (int i = 0; i < LOCK_RING_DEPTH && p != tail_ptr; i++) begin
				s = p[SLOT_W-1:0];
				if (slot_state[s] == ST_WAIT && (slot_mask[s] & busy) == '0 &&
				    step_results.size() < MAX_RESULTS) begin
					slot_state[s] = ST_HELD;
					add_result(KIND_GRANTED, s);
				end
				if (slot_state[s] == ST_WAIT || slot_state[s] == ST_HELD)
					busy |= slot_mask[s];
				p = p + 1'b1;
			end
		endfunction

		function void note_request(logic cmd, logic [MASK_IN_W-1:0] mask,
		                           logic [SLOT_W-1:0] slot);
			logic [SLOT_W-1:0] s;
			step_results.delete();
			if (cmd == CMD_ACQUIRE) begin
				if (live_count() >= LOCK_RING_DEPTH) begin
					add_result(KIND_FULL, '0);
				end else begin
					s             = tail_ptr[SLOT_W-1:0];
					slot_mask[s]  = mask;
					slot_state[s] = ST_WAIT;
					tail_ptr      = tail_ptr + 1'b1;
					add_result(KIND_ASSIGNED, s);
					scan_grants();
				end
			end else if (slot_state[slot] != ST_HELD) begin
				add_result(KIND_BADREL, slot);
			end else begin
				slot_mask[slot]  = '0;
				slot_state[slot] = ST_DONE;
				for (int i = 0; i < LOCK_RING_DEPTH && head_ptr != tail_ptr; i++) begin
					s = head_ptr[SLOT_W-1:0];
					if (slot_state[s] != ST_DONE)
						break;
					slot_state[s] = ST_FREE;
					head_ptr      = head_ptr + 1'b1;
				end
				scan_grants();
			end
			if (step_results.size() > 0)
				step_results[step_results.size() - 1].last = 1'b1;
			foreach (step_results[i])
				owed_results.push_back(step_results[i]);
		endfunction

		function void check_result(kind_t kind, logic [HANDLE_W-1:0] handle, logic last);
			lock_result_t e;
			if (owed_results.size() == 0) begin
				$display("%0t: unexpected result kind %0d handle %0d last %0d",
				         $time, kind, handle, last);
				mismatches++;
				return;
			end
			e = owed_results.pop_front();
			if (kind !== e.kind) begin
				$display("%0t: kind expected %0d, actual %0d", $time, e.kind, kind);
				mismatches++;
			end
			if (handle !== e.handle) begin
				$display("%0t: handle expected %0d, actual %0d", $time, e.handle, handle);
				mismatches++;
			end
			if (last !== e.last) begin
				$display("%0t: last expected %0d, actual %0d", $time, e.last, last);
				mismatches++;
			end
		endfunction
	endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives acquire and release requests into the lock queue with random gaps
// and result stalls, predicts handles, grants and errors per request and
// checks every result transfer in order
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mrlq_pkg::*;
	import mrlq_tb_pkg::*;

	logic clk = 1'b0;
	logic arst_n;

	mrlq_req_if req_ch ();
	mrlq_rsp_if rsp_ch ();

	multi_resource_lock_queue_top #(
		.RING_DEPTH     (LOCK_RING_DEPTH),
		.RESOURCE_COUNT (LOCK_RESOURCES)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	lock_grant_tracker lock_board = new();

	// idling switches, flipped per segment of the run
	bit idle_on  = 1'b0;
	bit stall_on = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#1_600_000;
		$display("FAILED: results differ");
		$finish;
	end

	// one request transfer, optionally preceded by an idle burst
	task automatic send_request(input logic cmd, input logic [MASK_IN_W-1:0] mask,
	                            input logic [SLOT_W-1:0] slot);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 19);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.cmd           <= cmd;
		req_ch.resource_mask <= mask;
		req_ch.slot          <= slot;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		lock_board.note_request(cmd, mask, slot);
	endtask

	task automatic acquire(input logic [MASK_IN_W-1:0] mask);
		send_request(CMD_ACQUIRE, mask, SLOT_W'($urandom));
	endtask

	task automatic release_slot(input logic [SLOT_W-1:0] slot);
		send_request(CMD_RELEASE, MASK_IN_W'($urandom), slot);
	endtask

	// mostly sparse masks so that requests both overlap and pass each other
	function automatic logic [MASK_IN_W-1:0] random_mask();
		logic [MASK_IN_W-1:0] m;
		case ($urandom_range(0, 9))
			0: m = '0;
			1: m = '1;
			2, 3: m = MASK_IN_W'($urandom);
			default: begin
				m = MASK_IN_W'(1) << $urandom_range(0, MASK_IN_W - 1);
				if ($urandom_range(0, 1) == 1)
					m |= MASK_IN_W'(1) << $urandom_range(0, MASK_IN_W - 1);
			end
		endcase
		return m;
	endfunction

	// result side: check each transfer, then decide ready for the next cycle
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
				lock_board.check_result(rsp_ch.kind, rsp_ch.handle, rsp_ch.last);
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// stimulus
	initial begin
		int roll;
		int held;
		int target;
		int fill_left;

		target    = 4;
		fill_left = 0;
		arst_n               <= 1'b0;
		req_ch.valid         <= 1'b0;
		req_ch.cmd           <= CMD_ACQUIRE;
		req_ch.resource_mask <= '0;
		req_ch.slot          <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: error cases, empty mask, full mask, chained unblocking
		release_slot(4'd0);          // free slot: bad release
		acquire('0);                 // empty mask: granted at once
		acquire('1);                 // all resources
		acquire(10'h001);            // waits behind the full mask
		acquire(10'h200);            // waits too
		release_slot(4'd2);          // waiting slot: bad release
		release_slot(4'd1);          // unblocks two waiters in one go
		release_slot(4'd1);          // already released: bad release
		release_slot(4'd0);          // head moves, no grant, no result
		acquire(10'h155);
		acquire(10'h2AA);
		release_slot(4'd2);
		release_slot(4'd3);
		release_slot(4'd15);         // highest slot, never used

		// random: ring occupancy steered toward a per-segment target,
		// fill bursts run into the ring-full reject, some noise releases
		for (int n = 0; n < 430; n++) begin
			if (n % 40 == 0) begin
				idle_on  = (n < 340) && ($urandom_range(0, 3) != 0);
				stall_on = (n < 340) && ($urandom_range(0, 3) != 0);
				target   = $urandom_range(1, LOCK_RING_DEPTH - 1);
			end
			if (n % 60 == 30 && $urandom_range(0, 1) == 1)
				fill_left = $urandom_range(LOCK_RING_DEPTH, LOCK_RING_DEPTH + 6);
			roll = $urandom_range(0, 99);
			held = lock_board.pick_held_slot();
			if (roll < 8) begin
				release_slot(SLOT_W'($urandom_range(0, LOCK_RING_DEPTH - 1)));
			end else if (fill_left > 0) begin
				fill_left--;
				acquire(random_mask());
			end else if (held < 0 || lock_board.live_count() < target) begin
				acquire(random_mask());
			end else begin
				release_slot(SLOT_W'(held));
			end
		end
		req_ch.valid <= 1'b0;
		stall_on = 1'b0;

		// drain, then give the block time to emit anything stray
		while (lock_board.owed_count() != 0)
			@(posedge clk);
		repeat (4 * LOCK_RING_DEPTH) @(posedge clk);

		if (lock_board.clean())
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
